// ===== rtl/core/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Shared sizes, codes, types and helpers of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int TABLE_DEPTH = 256;

   localparam int KEY_W      = 32;
   localparam int PAYLOAD_W  = 16;
   localparam int POS_W      = 8;
   localparam int CNT_OUT_W  = 9;
   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 2;

   localparam int IDX_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W      = (COUNT_W > CNT_OUT_W) ? COUNT_W : CNT_OUT_W;
   localparam int SEL_W      = IDX_W + KEY_W + PAYLOAD_W;

   localparam int TREE_RADIX  = 16;
   localparam int TREE_LEVELS = (TABLE_DEPTH <= 16)  ? 1 :
                                (TABLE_DEPTH <= 256) ? 2 :
                                (TABLE_DEPTH <= 4096) ? 3 : 4;
   localparam int WAIT_W      = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

   localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP_MIN = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_MAX = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ALTER   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd6;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd7;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   localparam logic [2:0] SEL_NONE  = 3'd0;
   localparam logic [2:0] SEL_BOUND = 3'd1;
   localparam logic [2:0] SEL_MATCH = 3'd2;
   localparam logic [2:0] SEL_FIRST = 3'd3;
   localparam logic [2:0] SEL_LAST  = 3'd4;
   localparam logic [2:0] SEL_POS   = 3'd5;

   localparam logic [2:0] ACT_HOLD       = 3'd0;
   localparam logic [2:0] ACT_INSERT     = 3'd1;
   localparam logic [2:0] ACT_REMOVE_GE  = 3'd2;
   localparam logic [2:0] ACT_REMOVE_ALL = 3'd3;
   localparam logic [2:0] ACT_WRITE      = 3'd4;

   typedef logic [SEL_W-1:0] sel_word_type;

   typedef struct packed {
      logic [2:0]           sel_kind;
      logic [2:0]           action;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic [POS_W-1:0]     position;
      logic [COUNT_W-1:0]   count;
   } cell_ctl_type;

   function automatic logic [POS_W-1:0] to_pos8(input logic [IDX_W-1:0] idx);
      logic [EXT_W-1:0] wide;
      wide = EXT_W'(idx);
      return wide[POS_W-1:0];
   endfunction

   function automatic logic [CNT_OUT_W-1:0] to_count9(input logic [COUNT_W-1:0] cnt);
      logic [EXT_W-1:0] wide;
      wide = EXT_W'(cnt);
      return wide[CNT_OUT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/skt_cell.sv =====
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: compares its key with the broadcast key, flags itself for
// the select tree and shifts with its neighbours on insert and removal.
// ----------------------------------------------------------------------------
module skt_cell (
   input  logic                         clock,
   input  skt_pkg::cell_ctl_type        ctl,
   input  logic [skt_pkg::IDX_W-1:0]    cell_index,
   input  logic                         prev_lt,
   input  logic [skt_pkg::KEY_W-1:0]    prev_key,
   input  logic [skt_pkg::PAYLOAD_W-1:0] prev_payload,
   input  logic [skt_pkg::KEY_W-1:0]    next_key,
   input  logic [skt_pkg::PAYLOAD_W-1:0] next_payload,
   output logic                         cell_lt,
   output logic [skt_pkg::KEY_W-1:0]    cell_key,
   output logic [skt_pkg::PAYLOAD_W-1:0] cell_payload,
   output logic                         cell_sel,
   output skt_pkg::sel_word_type        cell_data
);
   import skt_pkg::*;

   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic                 valid;
   logic                 bound;

   assign valid   = COUNT_W'(cell_index) < ctl.count;
   assign cell_lt = valid && (key_ff < ctl.key);
   assign bound   = prev_lt && !cell_lt && (COUNT_W'(cell_index) <= ctl.count);

   always_comb begin
      unique case (ctl.sel_kind)
         SEL_BOUND: cell_sel = bound;
         SEL_MATCH: cell_sel = bound && valid && (key_ff == ctl.key);
         SEL_FIRST: cell_sel = valid && (cell_index == IDX_W'(0));
         SEL_LAST:  cell_sel = valid && ((COUNT_W'(cell_index) + COUNT_W'(1)) == ctl.count);
         SEL_POS:   cell_sel = valid && (EXT_W'(cell_index) == EXT_W'(ctl.position));
         default:   cell_sel = 1'b0;
      endcase
   end

   assign cell_data    = cell_sel ? {cell_index, key_ff, payload_ff} : '0;
   assign cell_key     = key_ff;
   assign cell_payload = payload_ff;

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      unique case (ctl.action)
         ACT_INSERT: begin
            if (!cell_lt) begin
               if (prev_lt) begin
                  key_in     = ctl.key;
                  payload_in = ctl.payload;
               end else begin
                  key_in     = prev_key;
                  payload_in = prev_payload;
               end
            end
         end
         ACT_REMOVE_GE: begin
            if (!cell_lt) begin
               key_in     = next_key;
               payload_in = next_payload;
            end
         end
         ACT_REMOVE_ALL: begin
            key_in     = next_key;
            payload_in = next_payload;
         end
         ACT_WRITE: begin
            if (cell_sel) begin
               payload_in = ctl.payload;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

endmodule

// ===== rtl/core/skt_select_tree.sv =====
// ----------------------------------------------------------------------------
// skt_select_tree
// Registered OR tree that gathers the one flagged cell's index, key and
// payload, sixteen children per node and one register stage per level.
// ----------------------------------------------------------------------------
module skt_select_tree (
   input  logic                  clock,
   input  logic                  leaf_sel  [skt_pkg::TABLE_DEPTH],
   input  skt_pkg::sel_word_type leaf_data [skt_pkg::TABLE_DEPTH],
   output logic                  root_hit,
   output skt_pkg::sel_word_type root_data
);
   import skt_pkg::*;

   logic         node_hit  [TREE_LEVELS+1][TABLE_DEPTH];
   sel_word_type node_data [TREE_LEVELS+1][TABLE_DEPTH];

   genvar l, n, c;

   generate
      for (n = 0; n < TABLE_DEPTH; n++) begin : g_leaf
         assign node_hit[0][n]  = leaf_sel[n];
         assign node_data[0][n] = leaf_data[n];
      end

      for (l = 0; l < TREE_LEVELS; l++) begin : g_level
         localparam int SPAN  = 1 << (4 * (l + 1));
         localparam int NODES = (TABLE_DEPTH + SPAN - 1) / SPAN;
         for (n = 0; n < TABLE_DEPTH; n++) begin : g_node
            if (n < NODES) begin : g_real
               logic         child_hit  [TREE_RADIX];
               sel_word_type child_data [TREE_RADIX];
               logic         hit_ff, hit_in;
               sel_word_type data_ff, data_in;

               for (c = 0; c < TREE_RADIX; c++) begin : g_child
                  if (n * TREE_RADIX + c < TABLE_DEPTH) begin : g_in
                     assign child_hit[c]  = node_hit[l][n * TREE_RADIX + c];
                     assign child_data[c] = node_data[l][n * TREE_RADIX + c];
                  end else begin : g_pad
                     assign child_hit[c]  = 1'b0;
                     assign child_data[c] = '0;
                  end
               end

               always_comb begin
                  hit_in  = 1'b0;
                  data_in = '0;
                  for (int i = 0; i < TREE_RADIX; i++) begin
                     hit_in  = hit_in | child_hit[i];
                     data_in = data_in | child_data[i];
                  end
               end

               always_ff @(posedge clock) begin
                  hit_ff  <= hit_in;
                  data_ff <= data_in;
               end

               assign node_hit[l+1][n]  = hit_ff;
               assign node_data[l+1][n] = data_ff;
            end else begin : g_unused
               assign node_hit[l+1][n]  = 1'b0;
               assign node_data[l+1][n] = '0;
            end
         end
      end
   endgenerate

   assign root_hit  = node_hit[TREE_LEVELS][0];
   assign root_data = node_data[TREE_LEVELS][0];

endmodule

// ===== rtl/core/sorted_key_table_core.sv =====
// After the accepting edge the sequencer searches while the flagged cell's word climbs
// the select tree, then decides and registers the result; alter with a new key removes
// the old entry, then searches again for the new key's place. A new transaction is
// taken only when busy is low; the registered select tree over the cell row sets the pace.
// Reset clears the entry count and control at once; entries stay unknown until
// written. The receiver cannot stall: each result strobes for one cycle.
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Ascending key table built as a row of compare-and-shift cells with a
// sequencer and a registered select tree.
// ----------------------------------------------------------------------------
module sorted_key_table_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [skt_pkg::MODE_W-1:0]       req_mode,
   input  logic [skt_pkg::KEY_W-1:0]        req_search_key,
   input  logic [skt_pkg::KEY_W-1:0]        req_replacement_key,
   input  logic [skt_pkg::PAYLOAD_W-1:0]    req_payload_in,
   input  logic [skt_pkg::POS_W-1:0]        req_position_in,
   output logic                             rsp_valid,
   output logic [skt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [skt_pkg::KEY_W-1:0]        rsp_key_out,
   output logic [skt_pkg::PAYLOAD_W-1:0]    rsp_payload_out,
   output logic [skt_pkg::POS_W-1:0]        rsp_position_out,
   output logic [skt_pkg::CNT_OUT_W-1:0]    rsp_count_out
);
   import skt_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic                 phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [KEY_W-1:0]     skey_ff, skey_in;
   logic [KEY_W-1:0]     rkey_ff, rkey_in;
   logic [PAYLOAD_W-1:0] pl_ff, pl_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [KEY_W-1:0]     work_key_ff, work_key_in;
   logic [2:0]           sel_kind_ff, sel_kind_in;
   logic [KEY_W-1:0]     saved_key_ff, saved_key_in;
   logic [PAYLOAD_W-1:0] saved_pl_ff, saved_pl_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_W-1:0] rsp_pl_ff, rsp_pl_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [CNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [2:0]           action;
   cell_ctl_type         ctl;

   logic                 cell_lt      [TABLE_DEPTH];
   logic [KEY_W-1:0]     cell_key     [TABLE_DEPTH];
   logic [PAYLOAD_W-1:0] cell_payload [TABLE_DEPTH];
   logic                 cell_sel     [TABLE_DEPTH];
   sel_word_type         cell_data    [TABLE_DEPTH];

   logic                 tree_hit;
   sel_word_type         tree_data;
   logic [IDX_W-1:0]     tree_idx;
   logic [KEY_W-1:0]     tree_key;
   logic [PAYLOAD_W-1:0] tree_pl;

   assign busy = (state_ff != ST_IDLE);

   assign ctl.sel_kind = sel_kind_ff;
   assign ctl.action   = action;
   assign ctl.key      = work_key_ff;
   assign ctl.payload  = pl_ff;
   assign ctl.position = pos_ff;
   assign ctl.count    = count_ff;

   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         logic                 p_lt;
         logic [KEY_W-1:0]     p_key, n_key;
         logic [PAYLOAD_W-1:0] p_pl, n_pl;

         if (i == 0) begin : g_first
            assign p_lt  = 1'b1;
            assign p_key = '0;
            assign p_pl  = '0;
         end else begin : g_mid_prev
            assign p_lt  = cell_lt[i-1];
            assign p_key = cell_key[i-1];
            assign p_pl  = cell_payload[i-1];
         end

         if (i == TABLE_DEPTH - 1) begin : g_last
            assign n_key = '0;
            assign n_pl  = '0;
         end else begin : g_mid_next
            assign n_key = cell_key[i+1];
            assign n_pl  = cell_payload[i+1];
         end

         skt_cell u_cell (
            .clock        (clock),
            .ctl          (ctl),
            .cell_index   (IDX_W'(i)),
            .prev_lt      (p_lt),
            .prev_key     (p_key),
            .prev_payload (p_pl),
            .next_key     (n_key),
            .next_payload (n_pl),
            .cell_lt      (cell_lt[i]),
            .cell_key     (cell_key[i]),
            .cell_payload (cell_payload[i]),
            .cell_sel     (cell_sel[i]),
            .cell_data    (cell_data[i])
         );
      end
   endgenerate

   skt_select_tree u_tree (
      .clock     (clock),
      .leaf_sel  (cell_sel),
      .leaf_data (cell_data),
      .root_hit  (tree_hit),
      .root_data (tree_data)
   );

   assign tree_idx = tree_data[SEL_W-1 -: IDX_W];
   assign tree_key = tree_data[PAYLOAD_W +: KEY_W];
   assign tree_pl  = tree_data[PAYLOAD_W-1:0];

   always_comb begin
      state_in      = state_ff;
      wait_in       = wait_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      skey_in       = skey_ff;
      rkey_in       = rkey_ff;
      pl_in         = pl_ff;
      pos_in        = pos_ff;
      work_key_in   = work_key_ff;
      sel_kind_in   = sel_kind_ff;
      saved_key_in  = saved_key_ff;
      saved_pl_in   = saved_pl_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pl_in     = rsp_pl_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      action        = ACT_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in     = req_mode;
               skey_in     = req_search_key;
               rkey_in     = req_replacement_key;
               pl_in       = req_payload_in;
               pos_in      = req_position_in;
               work_key_in = req_search_key;
               phase_in    = 1'b0;
               wait_in     = '0;
               state_in    = ST_SEARCH;
               unique case (req_mode)
                  MODE_INSERT:  sel_kind_in = SEL_BOUND;
                  MODE_POP_MIN: sel_kind_in = SEL_FIRST;
                  MODE_POP_MAX: sel_kind_in = SEL_LAST;
                  MODE_REMOVE:  sel_kind_in = SEL_MATCH;
                  MODE_LOOKUP:  sel_kind_in = SEL_MATCH;
                  MODE_ALTER:   sel_kind_in = SEL_MATCH;
                  MODE_READ:    sel_kind_in = SEL_POS;
                  MODE_CLEAR:   sel_kind_in = SEL_NONE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (wait_ff == WAIT_W'(TREE_LEVELS - 1)) begin
               state_in = ST_DECIDE;
            end else begin
               wait_in = wait_ff + WAIT_W'(1);
            end
         end
         ST_DECIDE: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_key_in    = '0;
            rsp_pl_in     = '0;
            rsp_pos_in    = '0;
            unique case (mode_ff)
               MODE_INSERT: begin
                  if (count_ff == COUNT_W'(TABLE_DEPTH)) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     action     = ACT_INSERT;
                     count_in   = count_ff + COUNT_W'(1);
                     rsp_pos_in = to_pos8(tree_idx);
                  end
               end
               MODE_POP_MIN, MODE_POP_MAX, MODE_REMOVE: begin
                  if (!tree_hit) begin
                     rsp_status_in = STATUS_MISS;
                  end else begin
                     rsp_key_in = tree_key;
                     rsp_pl_in  = tree_pl;
                     rsp_pos_in = to_pos8(tree_idx);
                     count_in   = count_ff - COUNT_W'(1);
                     priority case (mode_ff)
                        MODE_POP_MIN: action = ACT_REMOVE_ALL;
                        MODE_POP_MAX: action = ACT_HOLD;
                        default:      action = ACT_REMOVE_GE;
                     endcase
                  end
               end
               MODE_LOOKUP, MODE_READ: begin
                  if (!tree_hit) begin
                     rsp_status_in = STATUS_MISS;
                  end else begin
                     rsp_key_in = tree_key;
                     rsp_pl_in  = tree_pl;
                     rsp_pos_in = to_pos8(tree_idx);
                  end
               end
               MODE_ALTER: begin
                  priority if (phase_ff) begin
                     action     = ACT_INSERT;
                     count_in   = count_ff + COUNT_W'(1);
                     rsp_key_in = saved_key_ff;
                     rsp_pl_in  = saved_pl_ff;
                     rsp_pos_in = to_pos8(tree_idx);
                  end else if (!tree_hit) begin
                     rsp_status_in = STATUS_MISS;
                  end else if (rkey_ff == skey_ff) begin
                     action     = ACT_WRITE;
                     rsp_key_in = tree_key;
                     rsp_pl_in  = tree_pl;
                     rsp_pos_in = to_pos8(tree_idx);
                  end else begin
                     action       = ACT_REMOVE_GE;
                     count_in     = count_ff - COUNT_W'(1);
                     saved_key_in = tree_key;
                     saved_pl_in  = tree_pl;
                     work_key_in  = rkey_ff;
                     sel_kind_in  = SEL_BOUND;
                     phase_in     = 1'b1;
                     wait_in      = '0;
                     state_in     = ST_SEARCH;
                     rsp_valid_in = 1'b0;
                  end
               end
               MODE_CLEAR: begin
                  count_in = '0;
               end
            endcase
            rsp_count_in = to_count9(count_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         phase_ff     <= 1'b0;
         count_ff     <= '0;
         sel_kind_ff  <= SEL_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sel_kind_ff  <= sel_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      skey_ff       <= skey_in;
      rkey_ff       <= rkey_in;
      pl_ff         <= pl_in;
      pos_ff        <= pos_in;
      work_key_ff   <= work_key_in;
      saved_key_ff  <= saved_key_in;
      saved_pl_ff   <= saved_pl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pl_ff     <= rsp_pl_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_key_out      = rsp_key_ff;
   assign rsp_payload_out  = rsp_pl_ff;
   assign rsp_position_out = rsp_pos_ff;
   assign rsp_count_out    = rsp_count_ff;

`ifndef ASSERT_OFF
   a_rsp_after_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DECIDE))
      else $error("result strobe without a decide cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_SEARCH))
      else $error("accepted transaction did not start a search");

   a_miss_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_position_out == '0))
      else $error("position reported with a failing status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |-> (count_ff == COUNT_W'(TABLE_DEPTH)))
      else $error("full status while the table has room");
`endif

endmodule

// ===== tb/sorted_key_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_core_tb
// Drives insert, pop, remove, lookup, alter, read and clear transactions into
// the sorted key table with random gaps. A tracker keeps its own sorted copy
// of the table and checks every strobed response field by field.
// ----------------------------------------------------------------------------
module sorted_key_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import skt_pkg::*;

   typedef struct {
      logic [STATUS_W-1:0]  status;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic [POS_W-1:0]     position;
      logic [CNT_OUT_W-1:0] count;
   } table_reply_type;

   class table_tracker;
      logic [KEY_W-1:0]     shadow_keys [TABLE_DEPTH];
      logic [PAYLOAD_W-1:0] shadow_payloads [TABLE_DEPTH];
      int unsigned          shadow_fill = 0;
      table_reply_type      awaited_replies [$];
      int unsigned          errors = 0;

      function int unsigned lower_bound(logic [KEY_W-1:0] k);
         int unsigned p;
         p = 0;
         while (p < shadow_fill && shadow_keys[p] < k) p++;
         return p;
      endfunction

      function void remove_at(int unsigned p);
         int unsigned i;
         for (i = p; i + 1 < shadow_fill; i++) begin
            shadow_keys[i]     = shadow_keys[i + 1];
            shadow_payloads[i] = shadow_payloads[i + 1];
         end
         shadow_fill--;
      endfunction

      function int unsigned place(logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] pl);
         int unsigned p;
         int unsigned i;
         p = lower_bound(k);
         for (i = shadow_fill; i > p; i--) begin
            shadow_keys[i]     = shadow_keys[i - 1];
            shadow_payloads[i] = shadow_payloads[i - 1];
         end
         shadow_keys[p]     = k;
         shadow_payloads[p] = pl;
         shadow_fill++;
         return p;
      endfunction

      function void apply_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] skey,
                                  logic [KEY_W-1:0] rkey, logic [PAYLOAD_W-1:0] pl,
                                  logic [POS_W-1:0] pos);
         table_reply_type r;
         int unsigned     p;
         r.status   = STATUS_OK;
         r.key      = '0;
         r.payload  = '0;
         r.position = '0;
         case (mode)
            MODE_INSERT: begin
               if (shadow_fill >= TABLE_DEPTH) r.status = STATUS_FULL;
               else r.position = POS_W'(place(skey, pl));
            end
            MODE_POP_MIN, MODE_POP_MAX: begin
               if (shadow_fill == 0) begin
                  r.status = STATUS_MISS;
               end else begin
                  p = (mode == MODE_POP_MIN) ? 0 : shadow_fill - 1;
                  r.key      = shadow_keys[p];
                  r.payload  = shadow_payloads[p];
                  r.position = POS_W'(p);
                  remove_at(p);
               end
            end
            MODE_REMOVE, MODE_LOOKUP, MODE_ALTER: begin
               p = lower_bound(skey);
               if (p >= shadow_fill || shadow_keys[p] != skey) begin
                  r.status = STATUS_MISS;
               end else begin
                  r.key      = shadow_keys[p];
                  r.payload  = shadow_payloads[p];
                  r.position = POS_W'(p);
                  if (mode == MODE_REMOVE) begin
                     remove_at(p);
                  end else if (mode == MODE_ALTER) begin
                     if (rkey == skey) begin
                        shadow_payloads[p] = pl;
                     end else begin
                        remove_at(p);
                        r.position = POS_W'(place(rkey, pl));
                     end
                  end
               end
            end
            MODE_READ: begin
               if (pos >= shadow_fill) begin
                  r.status = STATUS_MISS;
               end else begin
                  r.key      = shadow_keys[pos];
                  r.payload  = shadow_payloads[pos];
                  r.position = pos;
               end
            end
            default: shadow_fill = 0;
         endcase
         r.count = CNT_OUT_W'(shadow_fill);
         awaited_replies.push_back(r);
      endfunction

      function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
            errors++;
         end
      endfunction

      function void match_response(logic [STATUS_W-1:0] status, logic [KEY_W-1:0] key,
                                   logic [PAYLOAD_W-1:0] payload,
                                   logic [POS_W-1:0] position,
                                   logic [CNT_OUT_W-1:0] count);
         table_reply_type e;
         if (awaited_replies.size() == 0) begin
            $display("%0t ns: unexpected transaction, expected none, actual status %h key %h",
                     $time, status, key);
            errors++;
            return;
         end
         e = awaited_replies.pop_front();
         compare("status", e.status, status);
         compare("key_out", e.key, key);
         compare("payload_out", e.payload, payload);
         compare("position_out", e.position, position);
         compare("count_out", e.count, count);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [MODE_W-1:0]    req_mode = MODE_LOOKUP;
   logic [KEY_W-1:0]     req_search_key = '0;
   logic [KEY_W-1:0]     req_replacement_key = '0;
   logic [PAYLOAD_W-1:0] req_payload_in = '0;
   logic [POS_W-1:0]     req_position_in = '0;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [KEY_W-1:0]     rsp_key_out;
   logic [PAYLOAD_W-1:0] rsp_payload_out;
   logic [POS_W-1:0]     rsp_position_out;
   logic [CNT_OUT_W-1:0] rsp_count_out;

   table_tracker tracker;
   bit           no_idle = 1'b0;

   sorted_key_table_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_search_key      (req_search_key),
      .req_replacement_key (req_replacement_key),
      .req_payload_in      (req_payload_in),
      .req_position_in     (req_position_in),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_key_out         (rsp_key_out),
      .rsp_payload_out     (rsp_payload_out),
      .rsp_position_out    (rsp_position_out),
      .rsp_count_out       (rsp_count_out)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         tracker.match_response(rsp_status, rsp_key_out, rsp_payload_out,
                                rsp_position_out, rsp_count_out);
      end
   end

   task automatic send(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] skey,
                       input logic [KEY_W-1:0] rkey, input logic [PAYLOAD_W-1:0] pl,
                       input logic [POS_W-1:0] pos);
      int unsigned gap;
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_mode            <= mode;
      req_search_key      <= skey;
      req_replacement_key <= rkey;
      req_payload_in      <= pl;
      req_position_in     <= pos;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.apply_request(mode, skey, rkey, pl, pos);
   endtask

   task automatic wait_drained();
      int unsigned spent;
      spent = 0;
      start <= 1'b0;
      while (tracker.awaited_replies.size() != 0 && spent < 200) begin
         @(posedge clock);
         spent++;
      end
   endtask

   function automatic logic [KEY_W-1:0] draw_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            if (tracker.shadow_fill > 0)
               return tracker.shadow_keys[$urandom_range(0, tracker.shadow_fill - 1)];
            return KEY_W'($urandom_range(0, 40));
         end
         5, 6, 7: return KEY_W'($urandom_range(0, 40));
         8: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return 32'h8000_0000;
               default: return 32'h7fff_ffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] draw_position();
      int unsigned top;
      top = (tracker.shadow_fill > 255) ? 255 : tracker.shadow_fill;
      if ($urandom_range(0, 9) < 7) return POS_W'($urandom_range(0, top));
      return POS_W'($urandom_range(0, 255));
   endfunction

   task automatic random_item(input int unsigned grow_pct, input int unsigned shrink_pct,
                              input bit with_clear);
      int unsigned       roll;
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  skey;
      roll = $urandom_range(0, 99);
      if (roll < grow_pct) begin
         mode = MODE_INSERT;
      end else if (roll < grow_pct + shrink_pct) begin
         case ($urandom_range(0, 2))
            0: mode = MODE_POP_MIN;
            1: mode = MODE_POP_MAX;
            default: mode = MODE_REMOVE;
         endcase
      end else if (with_clear && roll == 99) begin
         mode = MODE_CLEAR;
      end else begin
         case ($urandom_range(0, 2))
            0: mode = MODE_LOOKUP;
            1: mode = MODE_ALTER;
            default: mode = MODE_READ;
         endcase
      end
      skey = draw_key();
      send(mode, skey, ($urandom_range(0, 4) == 0) ? skey : draw_key(),
           PAYLOAD_W'($urandom), draw_position());
   endtask

   initial begin
      tracker = new;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table
      send(MODE_POP_MIN, '0, '0, '0, '0);
      send(MODE_POP_MAX, '1, '1, '1, '1);
      send(MODE_LOOKUP, 32'd5, '0, '0, '0);
      send(MODE_READ, '0, '0, '0, 8'd0);
      // extremes and duplicates
      send(MODE_INSERT, 32'h0000_0000, '0, 16'h0000, '0);
      send(MODE_INSERT, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 8'hff);
      send(MODE_INSERT, 32'd5, '0, 16'h0001, '0);
      send(MODE_INSERT, 32'd5, '0, 16'h0002, '0);
      send(MODE_LOOKUP, 32'd5, '0, '0, '0);
      send(MODE_ALTER, 32'd5, 32'd5, 16'haaaa, '0);
      send(MODE_ALTER, 32'd5, 32'd0, 16'h5555, '0);
      send(MODE_ALTER, 32'd7, 32'd9, 16'h1234, '0);
      send(MODE_ALTER, 32'hffff_ffff, 32'd3, 16'h00ff, '0);
      send(MODE_REMOVE, 32'd5, '0, '0, '0);
      send(MODE_REMOVE, 32'd9, '0, '0, '0);
      send(MODE_READ, '0, '0, '0, 8'hff);
      send(MODE_READ, '0, '0, '0, 8'd1);
      send(MODE_READ, '0, '0, '0, 8'd2);
      send(MODE_POP_MIN, '0, '0, '0, '0);
      send(MODE_POP_MAX, '0, '0, '0, '0);
      send(MODE_INSERT, 32'h8000_0000, '0, 16'h8000, '0);
      send(MODE_CLEAR, '0, '0, '0, '0);
      send(MODE_LOOKUP, 32'h8000_0000, '0, '0, '0);
      send(MODE_INSERT, 32'h7fff_ffff, '0, 16'h7fff, '0);

      repeat (150) random_item(45, 25, 1'b1);
      wait_drained();
      // fill to capacity, then work the full table
      while (tracker.shadow_fill < TABLE_DEPTH) random_item(90, 0, 1'b0);
      repeat (40) random_item(50, 0, 1'b0);
      wait_drained();
      repeat (220) random_item(20, 55, 1'b1);

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.awaited_replies.size() != 0) begin
         $display("%0t ns: transactions left over, expected 0, actual %0d", $time,
                  tracker.awaited_replies.size());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
